[rtl/core/psl_pkg.sv]
`timescale 1ns / 1ps
package psl_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int RATE_BITS_DEF = 16;
	localparam int TAG_BITS_DEF  = 32;

	typedef enum logic [3:0] {
		ACT_INSERT   = 4'd0,
		ACT_SET_RATE = 4'd1,
		ACT_RAISE    = 4'd2,
		ACT_LOWER    = 4'd3,
		ACT_SET_TAG  = 4'd4,
		ACT_REMOVE   = 4'd5,
		ACT_FIRST    = 4'd6,
		ACT_LAST     = 4'd7,
		ACT_READ     = 4'd8,
		ACT_LIST     = 4'd9,
		ACT_CLEAR    = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_BADPOS   = 3'd1,
		STS_FULL     = 3'd2,
		STS_RANGE    = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POS_WAIT,
		S_POS_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SH_SETUP,
		S_SH_RD,
		S_SH_WR,
		S_FIN,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_POS,
		OP_POS_LATCH,
		OP_SCAN_RD,
		OP_SCAN_CHK,
		OP_SH_SETUP,
		OP_SH_RD,
		OP_SH_WR,
		OP_FIN,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} psl_cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    pos_ok;
		logic    orate_zero;
		logic    orate_max;
		logic    same_rate;
		logic    scan_end;
		logic    stop_hit;
		logic    hit;
		logic    shift_done;
	} psl_stat_t;

endpackage

[rtl/core/priority_sorted_list_unit.sv]
`timescale 1ns / 1ps
// channel   signals                                   handshake
// request   action, position, rate, tag               start && !busy
// result    status, result_position, result_rate,     done, one cycle each
//           result_tag, entry_count, last
// An action takes longer the more entries it scans and shifts, most for a move
// across the whole list; each entry scanned passes a read and a check state, and
// each entry shifted a read and a write state; the entry memory read is registered.
// Reset clears the count and the controller; entries need no clearing.
// The receiver cannot stall; list rate gives one result per matching entry, or one not-found.
module priority_sorted_list_unit #(
	parameter int DEPTH     = psl_pkg::DEPTH_DEF,
	parameter int RATE_BITS = psl_pkg::RATE_BITS_DEF,
	parameter int TAG_BITS  = psl_pkg::TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  action,
	input  logic [4:0]  position,
	input  logic [15:0] rate,
	input  logic [31:0] tag,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  result_position,
	output logic [15:0] result_rate,
	output logic [31:0] result_tag,
	output logic [5:0]  entry_count,
	output logic        last
);
	import psl_pkg::*;

	psl_cmd_t  cmd;
	psl_stat_t stat;

	psl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	psl_dp #(
		.DEPTH     (DEPTH),
		.RATE_BITS (RATE_BITS),
		.TAG_BITS  (TAG_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.position        (position),
		.rate            (rate),
		.tag             (tag),
		.done            (done),
		.status          (status),
		.result_position (result_position),
		.result_rate     (result_rate),
		.result_tag      (result_tag),
		.entry_count     (entry_count),
		.last            (last)
	);

endmodule

[rtl/core/psl_ctrl.sv]
`timescale 1ns / 1ps
module psl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  psl_pkg::psl_stat_t  stat,
	output psl_pkg::psl_cmd_t   cmd
);
	import psl_pkg::*;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    is_move;

	assign is_move = (stat.act == ACT_SET_RATE) || (stat.act == ACT_RAISE) ||
		(stat.act == ACT_LOWER);
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= STS_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd.op  = OP_NONE;
		cmd.st  = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.act)
					ACT_INSERT: begin
						if (stat.full) begin
							st_d    = STS_FULL;
							state_d = S_EMIT;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
					ACT_SET_RATE, ACT_RAISE, ACT_LOWER, ACT_SET_TAG, ACT_REMOVE,
					ACT_READ: begin
						if (!stat.pos_ok) begin
							st_d    = STS_BADPOS;
							state_d = S_EMIT;
						end else begin
							cmd.op  = OP_RD_POS;
							state_d = S_POS_WAIT;
						end
					end
					ACT_FIRST, ACT_LAST, ACT_LIST: state_d = S_SCAN_RD;
					default: begin
						st_d    = STS_OK;
						state_d = S_EMIT;
					end
				endcase
			end
			S_POS_WAIT: begin
				cmd.op  = OP_POS_LATCH;
				state_d = S_POS_CHK;
			end
			S_POS_CHK: begin
				st_d = STS_OK;
				case (stat.act)
					ACT_SET_TAG: state_d = S_FIN;
					ACT_REMOVE:  state_d = S_SH_SETUP;
					ACT_READ:    state_d = S_EMIT;
					default: begin
						if ((stat.act == ACT_RAISE && stat.orate_zero) ||
							(stat.act == ACT_LOWER && stat.orate_max)) begin
							st_d    = STS_RANGE;
							state_d = S_EMIT;
						end else if (stat.same_rate) begin
							state_d = S_EMIT;
						end else begin
							state_d = S_SCAN_RD;
						end
					end
				endcase
			end
			S_SCAN_RD: begin
				cmd.op = OP_SCAN_RD;
				if (stat.scan_end) begin
					if (stat.act == ACT_INSERT || is_move) begin
						state_d = S_SH_SETUP;
					end else begin
						st_d    = (stat.act == ACT_FIRST || stat.hit) ? STS_OK : STS_NOTFOUND;
						state_d = S_EMIT;
					end
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				cmd.op = OP_SCAN_CHK;
				if (stat.stop_hit) begin
					if (stat.act == ACT_FIRST) begin
						st_d    = STS_OK;
						state_d = S_EMIT;
					end else begin
						state_d = S_SH_SETUP;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SH_SETUP: begin
				cmd.op  = OP_SH_SETUP;
				state_d = S_SH_RD;
			end
			S_SH_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = stat.shift_done ? S_FIN : S_SH_WR;
			end
			S_SH_WR: begin
				cmd.op  = OP_SH_WR;
				state_d = S_SH_RD;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				st_d    = STS_OK;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.op  = OP_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/core/psl_dp.sv]
`timescale 1ns / 1ps
module psl_dp #(
	parameter int DEPTH     = psl_pkg::DEPTH_DEF,
	parameter int RATE_BITS = psl_pkg::RATE_BITS_DEF,
	parameter int TAG_BITS  = psl_pkg::TAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psl_pkg::psl_cmd_t  cmd,
	output psl_pkg::psl_stat_t stat,
	input  logic [3:0]         action,
	input  logic [4:0]         position,
	input  logic [15:0]        rate,
	input  logic [31:0]        tag,
	output logic               done,
	output logic [2:0]         status,
	output logic [5:0]         result_position,
	output logic [15:0]        result_rate,
	output logic [31:0]        result_tag,
	output logic [5:0]         entry_count,
	output logic               last
);
	import psl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [RATE_BITS-1:0] mem_rate [DEPTH];
	logic [TAG_BITS-1:0]  mem_tag  [DEPTH];
	logic [RATE_BITS-1:0] rd_rate_q;
	logic [TAG_BITS-1:0]  rd_tag_q;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic                 rd_en, wr_en;
	logic [RATE_BITS-1:0] wr_rate;
	logic [TAG_BITS-1:0]  wr_tag;

	action_t              act_q;
	logic [CW-1:0]        cnt_q, pos_q, idx_q, stop_q, found_q, dst_q, hitpos_q;
	logic                 pos_ok_q, dir_up_q, hit_q;
	logic [RATE_BITS-1:0] key_q, nr_q, orate_q, hitrate_q, skey;
	logic [TAG_BITS-1:0]  tagin_q, otag_q, hittag_q;
	logic                 is_move, eq, stop_c;

	logic                 done_q, last_q;
	logic [2:0]           status_q;
	logic [5:0]           rpos_q, count_q;
	logic [15:0]          rrate_q;
	logic [31:0]          rtag_q;

	assign is_move = (act_q == ACT_SET_RATE) || (act_q == ACT_RAISE) || (act_q == ACT_LOWER);
	assign skey    = is_move ? nr_q : key_q;
	assign eq      = (rd_rate_q == skey);
	always_comb begin
		case (act_q)
			ACT_INSERT:                            stop_c = (rd_rate_q > skey);
			ACT_FIRST, ACT_SET_RATE, ACT_RAISE,
			ACT_LOWER:                             stop_c = (rd_rate_q >= skey);
			default:                               stop_c = 1'b0;
		endcase
	end

	assign stat.act        = act_q;
	assign stat.full       = (cnt_q == CW'(DEPTH));
	assign stat.pos_ok     = pos_ok_q;
	assign stat.orate_zero = (orate_q == '0);
	assign stat.orate_max  = (orate_q == '1);
	assign stat.same_rate  = (orate_q == nr_q);
	assign stat.scan_end   = (idx_q == cnt_q);
	assign stat.stop_hit   = stop_c;
	assign stat.hit        = hit_q;
	assign stat.shift_done = (idx_q == stop_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_rate = rd_rate_q;
		wr_tag  = rd_tag_q;
		case (cmd.op)
			OP_RD_POS: begin
				rd_en   = 1'b1;
				rd_addr = pos_q[AW-1:0];
			end
			OP_SCAN_RD: rd_en = !stat.scan_end;
			OP_SH_RD: begin
				rd_en   = !stat.shift_done;
				rd_addr = dir_up_q ? AW'(idx_q - 1'b1) : AW'(idx_q + 1'b1);
			end
			OP_SH_WR: wr_en = 1'b1;
			OP_FIN: begin
				wr_addr = dst_q[AW-1:0];
				case (act_q)
					ACT_INSERT: begin
						wr_en   = 1'b1;
						wr_rate = key_q;
						wr_tag  = tagin_q;
					end
					ACT_SET_TAG: begin
						wr_en   = 1'b1;
						wr_rate = orate_q;
						wr_tag  = tagin_q;
					end
					ACT_SET_RATE, ACT_RAISE, ACT_LOWER: begin
						wr_en   = 1'b1;
						wr_rate = nr_q;
						wr_tag  = otag_q;
					end
					default: wr_en = 1'b0;
				endcase
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_rate[wr_addr] <= wr_rate;
			mem_tag[wr_addr]  <= wr_tag;
		end
		if (rd_en) begin
			rd_rate_q <= mem_rate[rd_addr];
			rd_tag_q  <= mem_tag[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: hit_q <= 1'b0;
				OP_SCAN_CHK: if (eq && (act_q == ACT_LAST || act_q == ACT_LIST)) hit_q <= 1'b1;
				OP_FIN: begin
					if (act_q == ACT_INSERT) cnt_q <= cnt_q + 1'b1;
					else if (act_q == ACT_REMOVE) cnt_q <= cnt_q - 1'b1;
				end
				OP_EMIT: begin
					done_q <= 1'b1;
					if (act_q == ACT_CLEAR) cnt_q <= '0;
				end
				default: hit_q <= hit_q;
			endcase
			if (cmd.op == OP_SCAN_CHK && eq && act_q == ACT_LIST && hit_q) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				act_q    <= action_t'(action);
				pos_ok_q <= (32'(position) < 32'(cnt_q));
				pos_q    <= CW'(position);
				key_q    <= RATE_BITS'(rate);
				nr_q     <= RATE_BITS'(rate);
				tagin_q  <= TAG_BITS'(tag);
				idx_q    <= '0;
			end
			OP_POS_LATCH: begin
				orate_q <= rd_rate_q;
				otag_q  <= rd_tag_q;
				dst_q   <= pos_q;
				if (act_q == ACT_RAISE) nr_q <= rd_rate_q - 1'b1;
				else if (act_q == ACT_LOWER) nr_q <= rd_rate_q + 1'b1;
			end
			OP_SCAN_RD: if (stat.scan_end && act_q != ACT_LAST) found_q <= cnt_q;
			OP_SCAN_CHK: begin
				idx_q <= idx_q + 1'b1;
				if (stop_c) found_q <= idx_q;
				if (eq && act_q == ACT_LAST) found_q <= idx_q;
				if (eq && act_q == ACT_LIST) begin
					hitpos_q  <= idx_q;
					hitrate_q <= rd_rate_q;
					hittag_q  <= rd_tag_q;
				end
			end
			OP_SH_SETUP: begin
				if (act_q == ACT_INSERT) begin
					dir_up_q <= 1'b1;
					idx_q    <= cnt_q;
					stop_q   <= found_q;
					dst_q    <= found_q;
				end else if (act_q == ACT_REMOVE) begin
					dir_up_q <= 1'b0;
					idx_q    <= pos_q;
					stop_q   <= cnt_q - 1'b1;
				end else if (found_q > pos_q) begin
					dir_up_q <= 1'b0;
					idx_q    <= pos_q;
					stop_q   <= found_q - 1'b1;
					dst_q    <= found_q - 1'b1;
				end else begin
					dir_up_q <= 1'b1;
					idx_q    <= pos_q;
					stop_q   <= found_q;
					dst_q    <= found_q;
				end
			end
			OP_SH_WR: idx_q <= dir_up_q ? idx_q - 1'b1 : idx_q + 1'b1;
			default: idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SCAN_CHK && eq && act_q == ACT_LIST && hit_q) begin
			status_q <= STS_OK;
			rpos_q   <= 6'(hitpos_q);
			rrate_q  <= 16'(hitrate_q);
			rtag_q   <= 32'(hittag_q);
			count_q  <= 6'(cnt_q);
			last_q   <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			status_q <= cmd.st;
			rpos_q   <= '0;
			rrate_q  <= '0;
			rtag_q   <= '0;
			count_q  <= (act_q == ACT_CLEAR) ? 6'd0 : 6'(cnt_q);
			last_q   <= 1'b1;
			if (cmd.st == STS_OK) begin
				case (act_q)
					ACT_INSERT: begin
						rpos_q  <= 6'(dst_q);
						rrate_q <= 16'(key_q);
						rtag_q  <= 32'(tagin_q);
					end
					ACT_SET_RATE, ACT_RAISE, ACT_LOWER: begin
						rpos_q  <= 6'(dst_q);
						rrate_q <= 16'(nr_q);
						rtag_q  <= 32'(otag_q);
					end
					ACT_SET_TAG: begin
						rpos_q  <= 6'(pos_q);
						rrate_q <= 16'(orate_q);
						rtag_q  <= 32'(tagin_q);
					end
					ACT_REMOVE, ACT_READ: begin
						rpos_q  <= 6'(pos_q);
						rrate_q <= 16'(orate_q);
						rtag_q  <= 32'(otag_q);
					end
					ACT_FIRST, ACT_LAST: rpos_q <= 6'(found_q);
					ACT_LIST: begin
						rpos_q  <= 6'(hitpos_q);
						rrate_q <= 16'(hitrate_q);
						rtag_q  <= 32'(hittag_q);
					end
					default: rpos_q <= '0;
				endcase
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign result_position = rpos_q;
	assign result_rate     = rrate_q;
	assign result_tag      = rtag_q;
	assign entry_count     = count_q;
	assign last            = last_q;

endmodule

[rtl/core/psl_chk.sv]
`timescale 1ns / 1ps
module psl_chk #(
	parameter int DEPTH = psl_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  entry_count,
	input logic        last
);
	import psl_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after request");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !done) else $error("result right after final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy) else $error("idle while results remain");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(entry_count) <= DEPTH) else $error("entry count beyond depth");

endmodule

bind priority_sorted_list_unit psl_chk #(.DEPTH(DEPTH)) u_psl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.entry_count (entry_count),
	.last        (last)
);

[tb/sv/priority_sorted_list_unit_tb.sv]
`timescale 1ns / 1ps
module priority_sorted_list_unit_tb;
	import psl_pkg::*;

	localparam int LIST_DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  pos;
		logic [15:0] rate;
		logic [31:0] tag;
		logic [5:0]  count;
		logic        last;
	} list_result_t;

	class list_scoreboard;
		logic [15:0]  rates[LIST_DEPTH];
		logic [31:0]  tags[LIST_DEPTH];
		int           count;
		list_result_t pending[$];
		int           errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void push(logic [2:0] st, int p, logic [15:0] r, logic [31:0] t, bit lst);
			list_result_t e;
			e.status = st;
			e.pos = p[5:0];
			e.rate = r;
			e.tag = t;
			e.count = count[5:0];
			e.last = lst;
			pending = {pending, e};
		endfunction

		function int first_at_least(logic [15:0] r);
			for (int i = 0; i < count; i++)
				if (rates[i] >= r)
					return i;
			return count;
		endfunction

		function int relocate(int p, logic [15:0] nr);
			int np;
			int dst;
			logic [31:0] t;
			if (rates[p] == nr)
				return p;
			np = first_at_least(nr);
			dst = (np > p) ? np - 1 : np;
			t = tags[p];
			if (dst > p) begin
				for (int i = p; i < dst; i++) begin
					rates[i] = rates[i + 1];
					tags[i] = tags[i + 1];
				end
			end else begin
				for (int i = p; i > dst; i--) begin
					rates[i] = rates[i - 1];
					tags[i] = tags[i - 1];
				end
			end
			rates[dst] = nr;
			tags[dst] = t;
			return dst;
		endfunction

		function void note_request(logic [3:0] act, logic [4:0] p, logic [15:0] r,
				logic [31:0] t);
			int i;
			int k;
			bit pos_ok;
			logic [15:0] nr;
			pos_ok = p < count;
			case (act)
				ACT_INSERT: begin
					if (count >= LIST_DEPTH) begin
						push(STS_FULL, 0, 0, 0, 1);
					end else begin
						i = 0;
						while (i < count && rates[i] <= r)
							i++;
						for (int n = count; n > i; n--) begin
							rates[n] = rates[n - 1];
							tags[n] = tags[n - 1];
						end
						rates[i] = r;
						tags[i] = t;
						count++;
						push(STS_OK, i, r, t, 1);
					end
				end
				ACT_SET_RATE, ACT_RAISE, ACT_LOWER: begin
					if (!pos_ok) begin
						push(STS_BADPOS, 0, 0, 0, 1);
					end else if (act == ACT_RAISE && rates[p] == 0) begin
						push(STS_RANGE, 0, 0, 0, 1);
					end else if (act == ACT_LOWER && rates[p] == 16'hffff) begin
						push(STS_RANGE, 0, 0, 0, 1);
					end else begin
						if (act == ACT_SET_RATE)
							nr = r;
						else if (act == ACT_RAISE)
							nr = rates[p] - 16'd1;
						else
							nr = rates[p] + 16'd1;
						i = relocate(p, nr);
						push(STS_OK, i, rates[i], tags[i], 1);
					end
				end
				ACT_SET_TAG: begin
					if (!pos_ok) begin
						push(STS_BADPOS, 0, 0, 0, 1);
					end else begin
						tags[p] = t;
						push(STS_OK, p, rates[p], t, 1);
					end
				end
				ACT_REMOVE: begin
					if (!pos_ok) begin
						push(STS_BADPOS, 0, 0, 0, 1);
					end else begin
						logic [15:0] orate;
						logic [31:0] otag;
						orate = rates[p];
						otag = tags[p];
						for (int j = p; j + 1 < count; j++) begin
							rates[j] = rates[j + 1];
							tags[j] = tags[j + 1];
						end
						count--;
						push(STS_OK, p, orate, otag, 1);
					end
				end
				ACT_FIRST: push(STS_OK, first_at_least(r), 0, 0, 1);
				ACT_LAST: begin
					i = count - 1;
					while (i >= 0 && rates[i] != r)
						i--;
					if (i >= 0)
						push(STS_OK, i, 0, 0, 1);
					else
						push(STS_NOTFOUND, 0, 0, 0, 1);
				end
				ACT_READ: begin
					if (!pos_ok)
						push(STS_BADPOS, 0, 0, 0, 1);
					else
						push(STS_OK, p, rates[p], tags[p], 1);
				end
				ACT_LIST: begin
					k = 0;
					for (int j = 0; j < count; j++) begin
						if (rates[j] == r) begin
							push(STS_OK, j, rates[j], tags[j], 0);
							k++;
						end
					end
					if (k == 0)
						push(STS_NOTFOUND, 0, 0, 0, 1);
					else
						pending[$].last = 1'b1;
				end
				ACT_CLEAR: begin
					count = 0;
					push(STS_OK, 0, 0, 0, 1);
				end
				default: push(STS_OK, 0, 0, 0, 1);
			endcase
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			if (got.pos !== want.pos)
				$display("%0t: result_position expected %0d actual %0d", $time, want.pos,
					got.pos);
			if (got.rate !== want.rate)
				$display("%0t: result_rate expected %h actual %h", $time, want.rate, got.rate);
			if (got.tag !== want.tag)
				$display("%0t: result_tag expected %h actual %h", $time, want.tag, got.tag);
			if (got.count !== want.count)
				$display("%0t: entry_count expected %0d actual %0d", $time, want.count,
					got.count);
			if (got.last !== want.last)
				$display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  action;
	logic [4:0]  position;
	logic [15:0] rate;
	logic [31:0] tag;
	logic        done;
	logic [2:0]  status;
	logic [5:0]  result_position;
	logic [15:0] result_rate;
	logic [31:0] result_tag;
	logic [5:0]  entry_count;
	logic        last;

	list_scoreboard sb;
	int             idle_pct;
	int             stall_cycles;

	priority_sorted_list_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .position(position), .rate(rate), .tag(tag),
		.done(done), .status(status), .result_position(result_position),
		.result_rate(result_rate), .result_tag(result_tag),
		.entry_count(entry_count), .last(last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(action, position, rate, tag);
		if (arst_n && done)
			sb.check_result({status, result_position, result_rate, result_tag,
				entry_count, last});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("priority_sorted_list_unit_tb: errors");
			$finish;
		end
	end

	task automatic send(logic [3:0] act, logic [4:0] p, logic [15:0] r, logic [31:0] t);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		position <= p;
		rate <= r;
		tag <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		int sel;
		int cnt;
		logic [15:0] r;
		cnt = sb.count;
		sel = $urandom_range(99);
		r = (sel[0] && cnt > 0) ? sb.rates[$urandom_range(cnt - 1)] : 16'($urandom_range(15));
		if ($urandom_range(9) == 0)
			r = 16'($urandom());
		if (sel < 30)
			send(ACT_INSERT, 5'($urandom()), r, $urandom());
		else if (sel < 96)
			send(4'($urandom_range(ACT_SET_RATE, ACT_LIST)),
				(cnt > 0 && $urandom_range(7) != 0) ? 5'($urandom_range(cnt - 1)) :
				5'($urandom()), r, $urandom());
		else if (sel < 98)
			send(ACT_CLEAR, 5'($urandom()), 16'($urandom()), $urandom());
		else
			send(4'($urandom_range(11, 15)), 5'($urandom()), 16'($urandom()), $urandom());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = '0;
		position = '0;
		rate = '0;
		tag = '0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_LAST, 0, 0, 0);
		send(ACT_READ, 0, 0, 0);
		send(ACT_INSERT, 0, 16'hffff, 32'hffffffff);
		send(ACT_INSERT, 0, 16'h0000, 32'h00000000);
		send(ACT_INSERT, 0, 16'h0005, 32'h12345678);
		send(ACT_INSERT, 0, 16'h0005, 32'habcdef01);
		send(ACT_RAISE, 0, 0, 0);
		send(ACT_LOWER, 4, 0, 0);
		send(ACT_SET_RATE, 1, 16'h0005, 0);
		send(ACT_SET_RATE, 0, 16'h0006, 0);
		send(ACT_RAISE, 3, 0, 0);
		send(ACT_LOWER, 0, 0, 0);
		send(ACT_SET_TAG, 2, 0, 32'h5a5a5a5a);
		send(ACT_SET_TAG, 31, 0, 0);
		send(ACT_FIRST, 0, 16'h0005, 0);
		send(ACT_FIRST, 0, 16'hffff, 0);
		send(ACT_LAST, 0, 16'h0005, 0);
		send(ACT_LAST, 0, 16'h0007, 0);
		send(ACT_LIST, 0, 16'h0005, 0);
		send(ACT_LIST, 0, 16'h0009, 0);
		send(ACT_READ, 3, 0, 0);
		send(ACT_REMOVE, 1, 0, 0);
		send(ACT_REMOVE, 5, 0, 0);
		send(4'd15, 5'h1f, 16'hffff, 32'hffffffff);
		drain();

		for (int i = 0; i < LIST_DEPTH + 1; i++)
			send(ACT_INSERT, 0, 16'h0007, $urandom());
		send(ACT_LIST, 0, 16'h0007, 0);
		send(ACT_SET_RATE, 31, 16'h0000, 0);
		send(ACT_SET_RATE, 0, 16'hffff, 0);
		send(ACT_CLEAR, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 19 : (ph == 1) ? 56 : 0;
			for (int n = 0; n < 70; n++)
				send_random();
			drain();
		end

		start <= 1'b0;
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("priority_sorted_list_unit_tb: clean");
		else
			$display("priority_sorted_list_unit_tb: errors");
		$finish;
	end

endmodule

[files.f]
rtl/core/psl_pkg.sv
rtl/core/psl_ctrl.sv
rtl/core/psl_dp.sv
rtl/core/priority_sorted_list_unit.sv
rtl/core/psl_chk.sv
tb/sv/priority_sorted_list_unit_tb.sv
